[rtl/dfsc_pkg.sv]
package dfsc_pkg;

    // Image and disk geometry
    localparam int IMAGE_BYTES  = 262144;
    localparam int MAX_TRACKS   = 42;
    localparam int SECTOR_BYTES = 256;

    localparam int IMG_AW  = $clog2(IMAGE_BYTES);
    localparam int SEC_LIM = IMAGE_BYTES / SECTOR_BYTES;
    // start sector of the last track plus any sector code stays below this bound
    localparam int SIDX_W  = $clog2(SEC_LIM + 21 * MAX_TRACKS + 256);
    localparam int TRK_IW  = $clog2(MAX_TRACKS + 1);

    // Stream widths
    localparam int S_TDATA_W = 64;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 16;

    typedef enum logic [1:0] {
        MODE_LOAD = 2'd0,
        MODE_OPEN = 2'd1,
        MODE_READ = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_BAD_TS  = 2'd1,
        STAT_NO_FILE = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LINK_T,
        ST_LINK_S,
        ST_DATA,
        ST_DONE
    } t_state;

    // Sectors per track, zoned
    function automatic logic [4:0] zone_sectors(input logic [7:0] trk);
        if (trk <= 8'd17) begin
            return 5'd21;
        end else if (trk <= 8'd24) begin
            return 5'd19;
        end else if (trk <= 8'd30) begin
            return 5'd18;
        end
        return 5'd17;
    endfunction

    typedef logic [SIDX_W-1:0] t_start_tab [2**TRK_IW];

    // First sector index of each track; entry 0 and tracks past the end are unused
    function automatic t_start_tab make_start_tab();
        t_start_tab          tab;
        logic [SIDX_W-1:0]   acc;
        acc = '0;
        for (int t = 0; t < 2**TRK_IW; t++) begin
            tab[t] = acc;
            if (t >= 1) begin
                acc = acc + SIDX_W'(zone_sectors(8'(t)));
            end
        end
        return tab;
    endfunction

    localparam t_start_tab TRACK_START = make_start_tab();

endpackage

[rtl/dfsc_ram.sv]
module dfsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/disk_file_sector_chain_reader_core.sv]
// Sector-chain file reader for a 1541-style disk image. Every input word
// gives one result word. s_tuser selects the operation: load stores one
// image byte, open sets the first track/sector and the length in 256-byte
// blocks, read returns the next file byte. At a sector boundary the block
// maps track/sector to an image offset (zones of 21, 19, 18 and 17 sectors),
// takes the first two sector bytes as the next link and returns the third.
// End of file is offset >= length*256; the last sector's byte count is not
// used. An invalid track/sector gives status 1 and leaves the state alone,
// a read with no file open or past the end gives status 2. Load, open,
// unused codes and refused reads go from idle straight to done; a read in
// a sector passes the data state, a boundary read both link states and
// the data state, as the image RAM has a single read port (three reads in
// a row at a boundary) and a registered read. The image RAM is not cleared
// after reset; its contents are undefined until loaded. A new word is
// taken while the previous result still waits in the output register.
module disk_file_sector_chain_reader_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [17:0] image_address, [25:18] write_data, [33:26] first_track,
    // [41:34] first_sector, [57:42] length_blocks, [63:58] zero
    input  logic [dfsc_pkg::S_TDATA_W-1:0]  s_tdata,
    // [1:0] mode
    input  logic [dfsc_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [7:0] read_byte, [8] at_eof, [10:9] status, [15:11] zero
    output logic [dfsc_pkg::M_TDATA_W-1:0]  m_tdata
);

    import dfsc_pkg::*;

    // Input word fields
    logic [17:0] in_addr;
    logic [7:0]  in_wdata;
    logic [7:0]  in_first_track;
    logic [7:0]  in_first_sector;
    logic [15:0] in_length;

    assign in_addr         = s_tdata[17:0];
    assign in_wdata        = s_tdata[25:18];
    assign in_first_track  = s_tdata[33:26];
    assign in_first_sector = s_tdata[41:34];
    assign in_length       = s_tdata[57:42];

    // File state
    t_state              r_state,        n_state;
    logic [23:0]         r_offset,       n_offset;
    logic [7:0]          r_cur_track,    n_cur_track;
    logic [7:0]          r_cur_sector,   n_cur_sector;
    logic [7:0]          r_link_track,   n_link_track;
    logic [7:0]          r_link_sector,  n_link_sector;
    logic [15:0]         r_blocks,       n_blocks;
    logic                r_open,         n_open;
    // Item payload
    logic [IMG_AW-1:0]   r_rd_addr,      n_rd_addr;
    logic [7:0]          r_byte,         n_byte;
    t_status             r_status,       n_status;
    // Output register
    logic                r_m_valid,      n_m_valid;
    logic [M_TDATA_W-1:0] r_m_data,      n_m_data;

    // Image RAM port
    logic                ram_we;
    logic [IMG_AW-1:0]   ram_raddr;
    logic [7:0]          ram_rdata;

    // Sector lookup, from the registered file state only
    logic                boundary;
    logic [7:0]          trk;
    logic [7:0]          sec;
    logic [4:0]          zone;
    logic [SIDX_W-1:0]   sidx;
    logic                ts_ok;
    logic [IMG_AW-1:0]   rd_base;
    logic                eof;
    logic                accept;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (r_state == ST_IDLE);
    assign m_tvalid = r_m_valid;
    assign m_tdata  = r_m_data;

    assign boundary = (r_offset[7:0] == 8'd0);
    assign trk      = boundary ? r_link_track  : r_cur_track;
    assign sec      = boundary ? r_link_sector : r_cur_sector;
    assign zone     = zone_sectors(trk);
    assign sidx     = TRACK_START[trk[TRK_IW-1:0]] + SIDX_W'(sec);
    assign ts_ok    = (trk != 8'd0) && (trk <= 8'(MAX_TRACKS))
                      && (sec < {3'b000, zone})
                      && (sidx < SIDX_W'(SEC_LIM));
    // pos is zero at a boundary, so one concatenation covers both cases
    assign rd_base  = IMG_AW'({sidx, r_offset[7:0]});
    assign eof      = (r_offset >= {r_blocks, 8'h00});

    always_comb begin
        n_state       = r_state;
        n_offset      = r_offset;
        n_cur_track   = r_cur_track;
        n_cur_sector  = r_cur_sector;
        n_link_track  = r_link_track;
        n_link_sector = r_link_sector;
        n_blocks      = r_blocks;
        n_open        = r_open;
        n_rd_addr     = r_rd_addr;
        n_byte        = r_byte;
        n_status      = r_status;
        n_m_data      = r_m_data;
        n_m_valid     = r_m_valid && !m_tready;
        ram_we        = 1'b0;
        ram_raddr     = r_rd_addr;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_byte   = 8'd0;
                    n_status = STAT_OK;
                    n_state  = ST_DONE;
                    case (t_mode'(s_tuser))
                        MODE_LOAD: begin
                            ram_we = (int'(in_addr) < IMAGE_BYTES);
                        end
                        MODE_OPEN: begin
                            n_link_track  = in_first_track;
                            n_link_sector = in_first_sector;
                            n_blocks      = in_length;
                            n_offset      = 24'd0;
                            n_open        = 1'b1;
                        end
                        MODE_READ: begin
                            if (!r_open || eof) begin
                                n_status = STAT_NO_FILE;
                            end else if (!ts_ok) begin
                                n_status = STAT_BAD_TS;
                            end else begin
                                ram_raddr = rd_base;
                                n_rd_addr = rd_base;
                                if (boundary) begin
                                    // link bytes first, then the data byte
                                    n_cur_track  = trk;
                                    n_cur_sector = sec;
                                    n_offset     = r_offset + 24'd3;
                                    n_state      = ST_LINK_T;
                                end else begin
                                    n_offset = r_offset + 24'd1;
                                    n_state  = ST_DATA;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_LINK_T: begin
                n_link_track = ram_rdata;
                n_rd_addr    = r_rd_addr + IMG_AW'(1);
                ram_raddr    = n_rd_addr;
                n_state      = ST_LINK_S;
            end
            ST_LINK_S: begin
                n_link_sector = ram_rdata;
                n_rd_addr     = r_rd_addr + IMG_AW'(1);
                ram_raddr     = n_rd_addr;
                n_state       = ST_DATA;
            end
            ST_DATA: begin
                n_byte  = ram_rdata;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                // hold the result until the output register is free
                if (!r_m_valid || m_tready) begin
                    n_m_valid = 1'b1;
                    n_m_data  = {5'b00000, r_status, r_open && eof, r_byte};
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_offset      <= 24'd0;
            r_cur_track   <= 8'd0;
            r_cur_sector  <= 8'd0;
            r_link_track  <= 8'd0;
            r_link_sector <= 8'd0;
            r_blocks      <= 16'd0;
            r_open        <= 1'b0;
            r_m_valid     <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_offset      <= n_offset;
            r_cur_track   <= n_cur_track;
            r_cur_sector  <= n_cur_sector;
            r_link_track  <= n_link_track;
            r_link_sector <= n_link_sector;
            r_blocks      <= n_blocks;
            r_open        <= n_open;
            r_m_valid     <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_addr <= n_rd_addr;
        r_byte    <= n_byte;
        r_status  <= n_status;
        r_m_data  <= n_m_data;
    end

    dfsc_ram #(
        .WIDTH (8),
        .DEPTH (IMAGE_BYTES)
    ) u_image_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (IMG_AW'(in_addr)),
        .i_wdata (in_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // A boundary read skips the two link bytes, so offsets 1 and 2 never occur
    a_no_link_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open |-> (r_offset[7:0] != 8'd1) && (r_offset[7:0] != 8'd2))
        else $error("file offset points at a link byte");

    // The offset never runs past the end of the file
    a_offset_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open |-> (r_offset <= {r_blocks, 8'h00}))
        else $error("file offset beyond file length");

    // Link fetch always starts at the first byte of a sector
    a_link_at_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LINK_T) |-> (r_rd_addr[7:0] == 8'd0))
        else $error("link fetch not at sector start");

    // A new result appears only out of the done state
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_m_valid) |-> ($past(r_state) == ST_DONE))
        else $error("result raised outside done state");

    // No image write while a read is in flight
    a_no_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == ST_IDLE))
        else $error("image write during read sequence");

endmodule

[tb/disk_file_sector_chain_reader_core_tb.sv]
module disk_file_sector_chain_reader_core_tb;

    import dfsc_pkg::*;

    localparam int RANDOM_WORDS = 60;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 1000000;

    // One input word, fields in the order they sit in s_tdata, mode in s_tuser
    typedef struct {
        logic [1:0]  mode;
        logic [17:0] image_addr;
        logic [7:0]  wr_data;
        logic [7:0]  trk;
        logic [7:0]  sec;
        logic [15:0] blocks;
    } t_req;

    typedef struct {
        logic [7:0] rd_byte;
        logic       eof;
        t_status    status;
    } t_reply;

    logic                   i_clk    = 1'b0;
    logic                   i_rst_n  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata  = '0;    // image_address, write_data, track, sector, blocks
    logic [S_TUSER_W-1:0]   s_tuser  = '0;    // mode
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;          // read_byte, at_eof, status

    disk_file_sector_chain_reader_core DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1 i_clk = ~i_clk;

    // Reader state as the block should hold it
    logic [7:0]  disk_image [IMAGE_BYTES];
    logic [23:0] file_pos   = '0;
    logic [7:0]  cur_trk    = '0;
    logic [7:0]  cur_sec    = '0;
    logic [7:0]  next_trk   = '0;
    logic [7:0]  next_sec   = '0;
    logic [15:0] file_len   = '0;
    logic        file_is_open = 1'b0;

    t_req   pending_words[$];
    t_reply awaiting_replies[$];
    t_req   word_on_bus;
    t_reply want;

    int tx_wait = 0;
    int rx_wait = 0;
    logic rx_hold = 1'b0;
    int words_sent = 0;
    int words_in = 0;
    int replies_in = 0;
    int n_total = 0;
    int n_fail = 0;
    int cycle_count = 0;
    int n_loads = 0, n_opens = 0, n_reads = 0, n_spare = 0;
    int n_starts = 0, n_bad = 0, n_refused = 0;

    function automatic int zone_count(input int trk);
        if (trk <= 17) return 21;
        if (trk <= 24) return 19;
        if (trk <= 30) return 18;
        return 17;
    endfunction

    // Byte offset of a sector in the image; 0 when the track or sector is out of range
    function automatic bit locate_sector(input int trk, input int sec, output int base);
        int acc;
        acc  = 0;
        base = 0;
        if (trk < 1 || trk > MAX_TRACKS) return 1'b0;
        if (sec >= zone_count(trk)) return 1'b0;
        for (int t = 1; t < trk; t++) acc += zone_count(t) * SECTOR_BYTES;
        acc += sec * SECTOR_BYTES;
        if (acc + SECTOR_BYTES > IMAGE_BYTES) return 1'b0;
        base = acc;
        return 1'b1;
    endfunction

    function automatic bit past_end();
        return file_pos >= {file_len, 8'h00};
    endfunction

    // Advance the reader by one accepted word and queue the reply it owes
    task automatic predict_reader(input t_req w);
        t_reply r;
        int     pos;
        int     base;
        logic [7:0] trk, sec;
        r.rd_byte = 8'h00;
        r.eof     = 1'b0;
        r.status  = STAT_OK;
        case (w.mode)
            MODE_LOAD: begin
                n_loads++;
                if (w.image_addr < IMAGE_BYTES) disk_image[w.image_addr] = w.wr_data;
            end
            MODE_OPEN: begin
                n_opens++;
                next_trk     = w.trk;
                next_sec     = w.sec;
                file_len     = w.blocks;
                file_pos     = '0;
                file_is_open = 1'b1;
            end
            MODE_READ: begin
                n_reads++;
                if (!file_is_open || past_end()) begin
                    r.status = STAT_NO_FILE;
                    n_refused++;
                end else begin
                    pos = int'(file_pos[7:0]);
                    trk = (pos == 0) ? next_trk : cur_trk;
                    sec = (pos == 0) ? next_sec : cur_sec;
                    if (!locate_sector(trk, sec, base)) begin
                        r.status = STAT_BAD_TS;
                        n_bad++;
                    end else if (pos == 0) begin
                        // sector start: take the link, return the first data byte
                        cur_trk   = trk;
                        cur_sec   = sec;
                        next_trk  = disk_image[base];
                        next_sec  = disk_image[base + 1];
                        r.rd_byte = disk_image[base + 2];
                        file_pos  = file_pos + 24'd3;
                        n_starts++;
                    end else begin
                        r.rd_byte = disk_image[base + pos];
                        file_pos  = file_pos + 24'd1;
                    end
                end
            end
            default: n_spare++;
        endcase
        r.eof = file_is_open && past_end();
        awaiting_replies.push_back(r);
    endtask

    // Stimulus helpers: unused fields of every word carry random bits
    function automatic t_req random_word(input logic [1:0] mode);
        t_req w;
        w.mode       = mode;
        w.image_addr = 18'($urandom);
        w.wr_data    = 8'($urandom);
        w.trk        = 8'($urandom);
        w.sec        = 8'($urandom);
        w.blocks     = 16'($urandom);
        return w;
    endfunction

    task automatic stage_load(input int addr, input int data);
        t_req w;
        w            = random_word(MODE_LOAD);
        w.image_addr = 18'(addr);
        w.wr_data    = 8'(data);
        pending_words.push_back(w);
    endtask

    task automatic stage_open(input int trk, input int sec, input int blocks);
        t_req w;
        w        = random_word(MODE_OPEN);
        w.trk    = 8'(trk);
        w.sec    = 8'(sec);
        w.blocks = 16'(blocks);
        pending_words.push_back(w);
    endtask

    task automatic stage_reads(input int n);
        for (int i = 0; i < n; i++) pending_words.push_back(random_word(MODE_READ));
    endtask

    task automatic stage_spare();
        pending_words.push_back(random_word(2'd3));
    endtask

    // Load the first nbytes of a sector, link bytes first
    task automatic stage_sector(input int trk, input int sec, input int nbytes,
                                input int link_t, input int link_s);
        int base;
        void'(locate_sector(trk, sec, base));
        for (int i = 0; i < nbytes; i++) begin
            stage_load(base + i, (i == 0) ? link_t : (i == 1) ? link_s : $urandom_range(0, 255));
        end
    endtask

    task automatic pick_sector(output int trk, output int sec);
        trk = $urandom_range(1, MAX_TRACKS);
        sec = $urandom_range(0, zone_count(trk) - 1);
    endtask

    task automatic pick_bad_sector(output int trk, output int sec);
        case ($urandom_range(0, 2))
            0: begin
                trk = 0;
                sec = $urandom_range(0, 255);
            end
            1: begin
                trk = $urandom_range(MAX_TRACKS + 1, 255);
                sec = $urandom_range(0, 255);
            end
            default: begin
                trk = $urandom_range(1, MAX_TRACKS);
                sec = $urandom_range(zone_count(trk), 255);
            end
        endcase
    endtask

    // Read a whole sector: to end of file, across a good link, or into a bad link
    task automatic stage_long_file(input int kind);
        int a_t, a_s, b_t, b_s, n;
        pick_sector(a_t, a_s);
        case (kind)
            0: begin
                stage_sector(a_t, a_s, SECTOR_BYTES, $urandom_range(0, 255), $urandom_range(0, 255));
                stage_open(a_t, a_s, 1);
                stage_reads(SECTOR_BYTES - 2 + 2);
            end
            1: begin
                do pick_sector(b_t, b_s); while (b_t == a_t && b_s == a_s);
                n = $urandom_range(3, 10);
                stage_sector(a_t, a_s, SECTOR_BYTES, b_t, b_s);
                stage_sector(b_t, b_s, n, $urandom_range(0, 255), $urandom_range(0, 255));
                stage_open(a_t, a_s, $urandom_range(2, 65535));
                stage_reads(SECTOR_BYTES - 2 + $urandom_range(1, n - 2));
            end
            default: begin
                pick_bad_sector(b_t, b_s);
                stage_sector(a_t, a_s, SECTOR_BYTES, b_t, b_s);
                stage_open(a_t, a_s, $urandom_range(2, 65535));
                stage_reads(SECTOR_BYTES - 2 + 2);
            end
        endcase
    endtask

    task automatic stage_short_file();
        int t, s, n;
        pick_sector(t, s);
        n = $urandom_range(3, 12);
        stage_sector(t, s, n, $urandom_range(0, 255), $urandom_range(0, 255));
        stage_open(t, s, ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(1, 65535));
        stage_reads($urandom_range(1, n - 2));
        // reopen mid-file and read again from the start
        if ($urandom_range(0, 3) == 0) begin
            stage_open(t, s, $urandom_range(1, 65535));
            stage_reads($urandom_range(1, n - 2));
        end
    endtask

    task automatic stage_broken();
        int t, s;
        if ($urandom_range(0, 1) == 0) begin
            pick_bad_sector(t, s);
            stage_open(t, s, $urandom_range(1, 65535));
            stage_reads($urandom_range(1, 3));
        end else begin
            pick_sector(t, s);
            stage_open(t, s, 0);
            stage_reads($urandom_range(1, 2));
        end
    endtask

    task automatic stage_noise();
        int n;
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 2) == 0) stage_spare();
            else stage_load($urandom_range(0, IMAGE_BYTES - 1), $urandom_range(0, 255));
        end
    endtask

    // Wait per word: every third stretch of 48 words runs back to back
    function automatic int draw_wait(input int idx);
        if ((idx / 48) % 3 == 2) return 0;
        return $urandom_range(0, 19);
    endfunction

    // Sender: hold the word until taken, then idle for the drawn gap
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_reader(word_on_bus);
                words_in++;
            end
            if (!s_tvalid || s_tready) begin
                if (tx_wait > 0) begin
                    tx_wait--;
                    s_tvalid <= 1'b0;
                end else if (pending_words.size() != 0) begin
                    word_on_bus = pending_words.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {6'd0, word_on_bus.blocks, word_on_bus.sec, word_on_bus.trk,
                                 word_on_bus.wr_data, word_on_bus.image_addr};
                    s_tuser  <= word_on_bus.mode;
                    tx_wait = draw_wait(words_sent);
                    words_sent++;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each reply against the oldest expectation
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (awaiting_replies.size() == 0) begin
                    n_fail++;
                    if (n_fail <= 10) $display("reply %0d with none pending: %h", replies_in, m_tdata);
                end else begin
                    want = awaiting_replies.pop_front();
                    if (m_tdata[7:0] !== want.rd_byte || m_tdata[8] !== want.eof ||
                            m_tdata[10:9] !== want.status) begin
                        n_fail++;
                        if (n_fail <= 10) begin
                            $display("reply %0d: expected byte %h eof %b status %0d, got %h %b %0d",
                                     replies_in, want.rd_byte, want.eof, want.status,
                                     m_tdata[7:0], m_tdata[8], m_tdata[10:9]);
                        end
                    end
                end
                rx_wait = draw_wait(replies_in + 24);
                replies_in++;
            end else if (rx_wait > 0) begin
                rx_wait--;
            end
            m_tready <= !rx_hold && rx_wait == 0;
        end
    end

    // Long back-pressure once the run is under way, so the block fills and stalls input
    initial begin
        wait (words_in >= 300);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk) cycle_count++;
        $display("timeout after %0d cycles, %0d replies pending", cycle_count,
                 awaiting_replies.size());
        $display("disk_file_sector_chain_reader_core regression: fail");
        $finish;
    end

    initial begin
        int goal;

        // Directed: no file, unused mode, address and data extremes
        stage_reads(1);
        stage_spare();
        stage_load(0, 8'h00);
        stage_load(IMAGE_BYTES - 1, 8'hFF);
        // bad tracks, and bad sectors at the edges of the first and last zones
        stage_open(0, 0, 16'hFFFF);
        stage_reads(1);
        stage_open(MAX_TRACKS + 1, 0, 1);
        stage_reads(1);
        stage_open(255, 255, 16'hFFFF);
        stage_reads(1);
        stage_open(1, 21, 5);
        stage_reads(1);
        stage_open(MAX_TRACKS, 17, 5);
        stage_reads(1);
        // zero-length file is at end right after the open
        stage_open(5, 3, 0);
        stage_reads(1);
        // first and last sector of the disk
        stage_sector(1, 0, 5, 8'h00, 8'hFF);
        stage_open(1, 0, 16'hFFFF);
        stage_reads(3);
        stage_sector(MAX_TRACKS, 16, 3, 8'hFF, 8'hFF);
        stage_open(MAX_TRACKS, 16, 1);
        stage_reads(1);

        // One file read through a whole sector; it alone takes about 500 words
        stage_long_file($urandom_range(0, 2));

        // Random: mostly well-formed files, some broken opens and noise
        goal = pending_words.size() + RANDOM_WORDS;
        while (pending_words.size() < goal) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: stage_short_file();
                6, 7:             stage_broken();
                default:          stage_noise();
            endcase
        end
        n_total = pending_words.size();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (words_in < n_total) @(posedge i_clk);
        while (awaiting_replies.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        n_fail += awaiting_replies.size();

        $display("sent %0d words: %0d loads, %0d opens, %0d reads, %0d unused-mode",
                 words_in, n_loads, n_opens, n_reads, n_spare);
        $display("reads: %0d sector starts, %0d bad track/sector, %0d refused; %0d failures",
                 n_starts, n_bad, n_refused, n_fail);
        if (n_fail == 0) begin
            $display("disk_file_sector_chain_reader_core regression: pass");
        end else begin
            $display("disk_file_sector_chain_reader_core regression: fail");
        end
        $finish;
    end

endmodule
